// ===== design/stepper_step_generator_ramp_core_assert.svh =====
// assertion macros for the step generator, used by ssgr_step
// expects signals named clk and rst_n in the module that uses them
`ifndef STEPPER_STEP_GENERATOR_RAMP_CORE_ASSERT_SVH
`define STEPPER_STEP_GENERATOR_RAMP_CORE_ASSERT_SVH

// same-cycle implication
`define SSGR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("step generator check failed");

// next-cycle implication
`define SSGR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("step generator check failed");

`endif

// ===== design/ssgr_pkg.sv =====
// shared types and codes for the stepper step generator
// no dependencies
package ssgr_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1;
  localparam logic [PERIOD_W-1:0] TARGET_RESET = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_PERIOD = 1'b0,
    CFG_DIRECTION     = 1'b1
  } cfg_idx_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_FORWARD  = 2'd0,
    DIR_BACKWARD = 2'd1,
    DIR_HOLD     = 2'd2
  } dir_t;

  typedef struct packed {
    logic                    step_pulse;
    logic signed [POS_W-1:0] position;
    logic [PERIOD_W-1:0]     period_now;
  } result_t;

endpackage

// ===== design/ssgr_step.sv =====
// step decision, ramp and position state for the step generator
// depends on ssgr_pkg and the assertion macro header
`include "stepper_step_generator_ramp_core_assert.svh"

module ssgr_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ssgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssgr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            en,
  input  logic [ssgr_pkg::TIME_W-1:0]     now,
  output ssgr_pkg::result_t               res
);

  logic [ssgr_pkg::PERIOD_W-1:0] target_r;
  logic [ssgr_pkg::DIR_W-1:0]    dir_r;
  logic [ssgr_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic [ssgr_pkg::TIME_W-1:0]   last_r;
  logic [ssgr_pkg::POS_W-1:0]    count_r, count_nxt;
  logic [ssgr_pkg::TIME_W:0]     due;
  logic                          fire;

  // due time kept in 33 bits so it never wraps
  assign due  = {1'b0, last_r} + {{(ssgr_pkg::TIME_W + 1 - ssgr_pkg::PERIOD_W){1'b0}}, period_r};
  assign fire = (period_r != '0) && ({1'b0, now} >= due);

  always_comb begin
    period_nxt = period_r;
    if (period_r < target_r) begin
      period_nxt = period_r + 16'd1;
    end else if (period_r > target_r) begin
      period_nxt = period_r - 16'd1;
    end
  end

  always_comb begin
    case (ssgr_pkg::dir_t'(dir_r))
      ssgr_pkg::DIR_FORWARD:  count_nxt = count_r + 16'd1;
      ssgr_pkg::DIR_BACKWARD: count_nxt = count_r - 16'd1;
      default:                count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= ssgr_pkg::TARGET_RESET;
      dir_r    <= ssgr_pkg::DIR_FORWARD;
      period_r <= ssgr_pkg::PERIOD_RESET;
      last_r   <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (ssgr_pkg::cfg_idx_t'(cfg_index))
          ssgr_pkg::CFG_TARGET_PERIOD: target_r <= cfg_data[ssgr_pkg::PERIOD_W-1:0];
          ssgr_pkg::CFG_DIRECTION:     dir_r    <= cfg_data[ssgr_pkg::DIR_W-1:0];
          default: ;
        endcase
      end
      if (en && fire) begin
        period_r <= period_nxt;
        last_r   <= now;
        count_r  <= count_nxt;
      end
    end
  end

  always_comb begin
    res.step_pulse = fire;
    res.position   = fire ? $signed(count_nxt) : $signed(count_r);
    res.period_now = fire ? period_nxt : period_r;
  end

  `SSGR_ASSERT_NOW(a_zero_period_halts, period_r == '0, !fire)
  `SSGR_ASSERT_NEXT(a_idle_state_holds, !(en && fire),
    $stable(period_r) && $stable(last_r) && $stable(count_r))
  `SSGR_ASSERT_NEXT(a_step_records_time, en && fire, last_r == $past(now))
  `SSGR_ASSERT_NEXT(a_forward_counts_up, en && fire && dir_r == ssgr_pkg::DIR_FORWARD,
    count_r == 16'($past(count_r) + 16'd1))

endmodule

// ===== design/stepper_step_generator_ramp_core.sv =====
// each item passes the input register, then the result register; it moves on into the result
// register once the result stage can take it, so a result-side stall holds it in the input register
// throughput: one item per cycle while the result side does not stall; the step state updates in
// the same cycle the item leaves the input register, so the next item sees it with no gap
// reset: synchronous active-low rst_n clears both stages, period to 1, position and
// last step time to 0, target period to 1 and direction to forward
module stepper_step_generator_ramp_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ssgr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssgr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ssgr_pkg::TIME_W-1:0]          in_now_ms,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_step_pulse,
  output logic signed [ssgr_pkg::POS_W-1:0]    out_position,
  output logic [ssgr_pkg::PERIOD_W-1:0]        out_period_now
);

  logic                        in_valid_r;
  logic [ssgr_pkg::TIME_W-1:0] now_r;
  logic                        out_valid_r;
  ssgr_pkg::result_t           res_r;
  ssgr_pkg::result_t           res;
  logic                        advance;

  // the result stage can take a new item when empty or when its item transfers
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;

  ssgr_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .en        (in_valid_r && advance),
    .now       (now_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      now_r <= in_now_ms;
    end
    if (advance && in_valid_r) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_step_pulse = res_r.step_pulse;
  assign out_position   = res_r.position;
  assign out_period_now = res_r.period_now;

endmodule

// ===== tb/sv/stepper_step_generator_ramp_core_test.sv =====
// self-checking bench for stepper_step_generator_ramp_core: a directed table, random
// timestamp runs under varying idle patterns and a due-time overflow
// depends on ssgr_pkg and the step generator core
module stepper_step_generator_ramp_core_test;
  import ssgr_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int BLOCKS      = 5;
  localparam int BLOCK_ITEMS = 40;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
    logic [TIME_W-1:0]     now;
    logic                  literal;
    result_t               lit_res;
  } plan_row_t;

  // after reset: period 1, target 1, forward, last step at 0
  localparam plan_row_t PLAN [0:22] = '{
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h0000_0000, 1'b1, '{1'b0,  16'sd0, 16'd1}},
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h0000_0001, 1'b1, '{1'b1,  16'sd1, 16'd1}},
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h0000_0000, 1'b1, '{1'b0,  16'sd1, 16'd1}},
    '{ROW_CFG,  CFG_DIRECTION,     16'h0001, 32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h0000_0002, 1'b1, '{1'b1,  16'sd0, 16'd1}},
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h0000_0003, 1'b1, '{1'b1, -16'sd1, 16'd1}},
    '{ROW_CFG,  CFG_DIRECTION,     16'h0002, 32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h0000_0004, 1'b1, '{1'b1, -16'sd1, 16'd1}},
    // direction code 3 with junk in the upper bits
    '{ROW_CFG,  CFG_DIRECTION,     16'hFFF7, 32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h0000_0005, 1'b1, '{1'b1, -16'sd1, 16'd1}},
    '{ROW_CFG,  CFG_DIRECTION,     16'hFFFC, 32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,  CFG_TARGET_PERIOD, 16'hFFFF, 32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h0000_0006, 1'b1, '{1'b1,  16'sd0, 16'd2}},
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h0000_0007, 1'b1, '{1'b0,  16'sd0, 16'd2}},
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h0000_0008, 1'b0, '0},
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h8000_0000, 1'b0, '0},
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_CFG,  CFG_TARGET_PERIOD, 16'h0000, 32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h8000_0003, 1'b0, '0},
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h8000_0004, 1'b0, '0},
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h8000_0007, 1'b0, '0},
    '{ROW_CFG,  CFG_TARGET_PERIOD, 16'h0003, 32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, CFG_TARGET_PERIOD, 16'h0000, 32'h8000_0009, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_TARGET_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_step_pulse;
  logic signed [POS_W-1:0] out_position;
  logic [PERIOD_W-1:0]   out_period_now;

  // predicted block state and registers
  logic [PERIOD_W-1:0]     tgt_period = TARGET_RESET;
  logic [DIR_W-1:0]        dir_code = DIR_FORWARD;
  logic [PERIOD_W-1:0]     cur_period = PERIOD_RESET;
  logic [TIME_W-1:0]       prev_step_ms = '0;
  logic signed [POS_W-1:0] step_count = '0;

  result_t awaited_steps[$];
  result_t want_res;
  int      err_count = 0;
  int      send_idle_pct = 37;
  int      recv_idle_pct = 62;
  bit      hold_req = 1'b0;

  always #5 clk = ~clk;

  stepper_step_generator_ramp_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_step_pulse (out_step_pulse),
    .out_position   (out_position),
    .out_period_now (out_period_now)
  );

  function automatic result_t advance_ramp(input logic [TIME_W-1:0] now);
    logic [TIME_W:0] due;
    logic            fire;
    result_t         res;
    // due time kept one bit wider so it never wraps
    due  = {1'b0, prev_step_ms} + {{(TIME_W+1-PERIOD_W){1'b0}}, cur_period};
    fire = (cur_period != '0) && ({1'b0, now} >= due);
    if (fire) begin
      if (cur_period < tgt_period) cur_period = cur_period + 1'b1;
      else if (cur_period > tgt_period) cur_period = cur_period - 1'b1;
      prev_step_ms = now;
      if (dir_code == DIR_FORWARD) step_count = step_count + 16'sd1;
      else if (dir_code == DIR_BACKWARD) step_count = step_count - 16'sd1;
    end
    res.step_pulse = fire;
    res.position   = step_count;
    res.period_now = cur_period;
    return res;
  endfunction

  function automatic logic [TIME_W-1:0] pick_now();
    int unsigned       roll;
    logic [TIME_W-1:0] v;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      v = prev_step_ms + cur_period + $urandom_range(0, 3);
    end else if (roll < 80) begin
      v = prev_step_ms + ((cur_period > 1) ? $urandom_range(0, cur_period - 1) : 0);
    end else if (roll < 88) begin
      v = (prev_step_ms > 1000) ? prev_step_ms - $urandom_range(1, 1000) : prev_step_ms;
    end else begin
      v = $urandom;
      // keep stepping clear of the top of the time range until the final overflow check
      if (v >= 32'hC000_0000 && v >= prev_step_ms + cur_period) v = v - 32'h4000_0000;
    end
    return v;
  endfunction

  task automatic send_item(input logic [TIME_W-1:0] now, input bit use_lit,
                           input result_t lit);
    result_t predicted;
    while (int'($urandom_range(0, 99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_now_ms <= now;
    do @(posedge clk); while (in_stall);
    predicted = advance_ramp(now);
    awaited_steps.push_back(use_lit ? lit : predicted);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_steps.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TARGET_PERIOD: tgt_period = data;
      CFG_DIRECTION:     dir_code = data[DIR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic retune();
    logic [PERIOD_W-1:0] tgt;
    int unsigned         roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) tgt = 16'($urandom_range(1, 6));
    else if (roll < 7) tgt = 16'($urandom_range(7, 300));
    else if (roll == 7) tgt = 16'hFFFF;
    else if (roll == 8) tgt = 16'($urandom_range(0, 65535));
    else tgt = '0;
    // a zero target only while the period is too long to reach zero within one block
    if (tgt == '0 && cur_period <= BLOCK_ITEMS + 20) tgt = 16'd1;
    write_reg(CFG_TARGET_PERIOD, tgt);
    write_reg(CFG_DIRECTION, 16'($urandom_range(0, 65535)));
  endtask

  // result side: stall pattern plus an occasional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= (int'($urandom_range(0, 99)) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_steps.size() == 0) begin
        $error("result transfer with no expectation waiting");
        err_count++;
      end else begin
        want_res = awaited_steps.pop_front();
        if (out_step_pulse !== want_res.step_pulse) begin
          $error("step_pulse mismatch: expected %0d, actual %0d",
                 want_res.step_pulse, out_step_pulse);
          err_count++;
        end
        if (out_position !== want_res.position) begin
          $error("position mismatch: expected %0d, actual %0d",
                 want_res.position, out_position);
          err_count++;
        end
        if (out_period_now !== want_res.period_now) begin
          $error("period_now mismatch: expected %0d, actual %0d",
                 want_res.period_now, out_period_now);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer or register write
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[stepper_step_generator_ramp_core] ERROR");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < $size(PLAN); r++) begin
      if (PLAN[r].kind == ROW_CFG) begin
        drain();
        write_reg(PLAN[r].idx, PLAN[r].data);
      end else begin
        send_item(PLAN[r].now, PLAN[r].literal, PLAN[r].lit_res);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 62 : 0;
      recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 37 : 0;
      for (int blk = 0; blk < BLOCKS; blk++) begin
        drain();
        retune();
        // fill the first block of phases 0 and 2 against a stalled result side
        if (blk == 0 && ph != 1) hold_req = 1'b1;
        for (int k = 0; k < BLOCK_ITEMS; k++) send_item(pick_now(), 1'b0, '0);
      end
    end

    drain();
    write_reg(CFG_TARGET_PERIOD, 16'd1);

    // step at the top of the time range, after which the due time no longer fits
    send_idle_pct = 37;
    recv_idle_pct = 62;
    send_item(32'hFFFF_FFFF - cur_period, 1'b0, '0);
    send_item(32'hFFFF_FFFF, 1'b0, '0);
    send_item(32'hFFFF_FFFF, 1'b0, '0);
    send_item(32'h0000_0000, 1'b0, '0);
    send_item($urandom, 1'b0, '0);
    send_item(32'hFFFF_FFFE, 1'b0, '0);
    drain();
    repeat (4) @(posedge clk);

    if (err_count == 0) begin
      $display("[stepper_step_generator_ramp_core] OK");
    end else begin
      $display("[stepper_step_generator_ramp_core] ERROR");
    end
    $finish;
  end

endmodule
